### rtl/imufp_pkg.sv
`timescale 1ns / 1ps

package imufp_pkg;

    // Frame geometry defaults
    localparam int PACKET_BYTES_DEF       = 11;
    localparam int PACKETS_PER_BUFFER_DEF = 3;

    // Fixed packet layout: bytes 2..9 carry the four data words
    localparam int POS_TYPE      = 1;
    localparam int POS_DATA_LO   = 2;
    localparam int POS_DATA_LAST = 9;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_TYPE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TYPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_TYPE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  HEAD_BYTE_RST      = 8'd85;
    localparam logic [7:0]  GYRO_TYPE_RST      = 8'd82;
    localparam logic [7:0]  ANGLE_TYPE_RST     = 8'd83;
    localparam logic [7:0]  QUAT_TYPE_RST      = 8'd89;
    localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd54613;

    // Packet kind codes on the result
    localparam logic [1:0] KIND_RATE  = 2'd0;
    localparam logic [1:0] KIND_ANGLE = 2'd1;
    localparam logic [1:0] KIND_QUAT  = 2'd2;

    // Request into the yaw unwrap unit
    typedef struct packed {
        logic        en;
        logic [15:0] yaw;
        logic [15:0] thr;
    } t_unwrap_req;

endpackage

### rtl/imufp_unwrap.sv
`timescale 1ns / 1ps

module imufp_unwrap (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  imufp_pkg::t_unwrap_req   i_req,
    output logic signed [31:0]       o_yaw_cont
);

    logic signed [15:0] r_last;
    logic signed [15:0] r_count;
    logic signed [15:0] n_count;
    logic signed [16:0] diff;
    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic signed [32:0] sum;

    // Jump against the previous yaw, exact in 17 bits
    always_comb begin
        diff    = {i_req.yaw[15], i_req.yaw} - {r_last[15], r_last};
        thr_pos = $signed({1'b0, i_req.thr});
        thr_neg = 17'sd0 - thr_pos;
        n_count = r_count;
        if (diff > thr_pos && r_count != 16'sh8000) begin
            n_count = r_count - 16'sd1;
        end
        if (diff < thr_neg && r_count != 16'sh7FFF) begin
            n_count = r_count + 16'sd1;
        end
        sum = $signed({n_count[15], n_count, 16'h0000})
            + $signed({{17{i_req.yaw[15]}}, i_req.yaw});
    end

    // Saturate to 32 bits
    always_comb begin
        if (sum[32] != sum[31]) begin
            o_yaw_cont = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_yaw_cont = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_count <= '0;
        end else if (i_req.en) begin
            r_last  <= i_req.yaw;
            r_count <= n_count;
        end
    end

endmodule

### rtl/imu_frame_parser_yaw_unwrap.sv
`timescale 1ns / 1ps

// A result appears on the master side in the cycle after packet byte 9 is accepted.
// Throughput: one byte per cycle while the master side is not stalled; the per-byte parse
// and yaw unwrap are combinational between the byte transfer and the output register.
// Reset (synchronous, active low) restores register defaults, clears the parser
// position, abort flag, rotation count and last yaw, and empties the output register.
module imu_frame_parser_yaw_unwrap #(
    parameter int PACKET_BYTES       = imufp_pkg::PACKET_BYTES_DEF,
    parameter int PACKETS_PER_BUFFER = imufp_pkg::PACKETS_PER_BUFFER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // rx_byte
    input  logic [0:0]                        i_s_tuser,  // buffer_start
    // result stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [95:0]                       o_m_tdata,  // word_a, word_b, word_c,
                                                          // word_d, yaw_continuous
    output logic [1:0]                        o_m_tuser,  // packet_kind
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [imufp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam int IDX_W = $clog2(PACKETS_PER_BUFFER + 1);

    // Configuration registers
    logic [7:0]  r_head;
    logic [7:0]  r_gyro;
    logic [7:0]  r_angle;
    logic [7:0]  r_quat;
    logic [15:0] r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= imufp_pkg::HEAD_BYTE_RST;
            r_gyro  <= imufp_pkg::GYRO_TYPE_RST;
            r_angle <= imufp_pkg::ANGLE_TYPE_RST;
            r_quat  <= imufp_pkg::QUAT_TYPE_RST;
            r_thr   <= imufp_pkg::WRAP_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                imufp_pkg::REG_HEAD_BYTE:      r_head  <= i_cfg_data[7:0];
                imufp_pkg::REG_GYRO_TYPE:      r_gyro  <= i_cfg_data[7:0];
                imufp_pkg::REG_ANGLE_TYPE:     r_angle <= i_cfg_data[7:0];
                imufp_pkg::REG_QUAT_TYPE:      r_quat  <= i_cfg_data[7:0];
                imufp_pkg::REG_WRAP_THRESHOLD: r_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state
    logic [POS_W-1:0] r_pos, n_pos, pos_e;
    logic [IDX_W-1:0] r_idx, n_idx, idx_e;
    logic             r_abort, n_abort, abort_e;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_hold, n_hold;
    logic [15:0]      r_words [4];
    logic [15:0]      n_words [4];
    logic [POS_W-1:0] data_off;
    logic [7:0]       rx;
    logic             active;
    logic             emit;
    logic [1:0]       kind;
    logic             accept;

    // Output register
    logic                r_out_valid;
    logic [1:0]          r_out_kind;
    logic [15:0]         r_out_a, r_out_b, r_out_c, r_out_d;
    logic signed [31:0]  r_out_yaw;

    imufp_pkg::t_unwrap_req unwrap_req;
    logic signed [31:0]     yaw_cont;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign rx         = i_s_tdata;

    // Next parser state for the byte on the input
    always_comb begin
        pos_e    = i_s_tuser[0] ? '0   : r_pos;
        idx_e    = i_s_tuser[0] ? '0   : r_idx;
        abort_e  = i_s_tuser[0] ? 1'b0 : r_abort;
        active   = !abort_e && (idx_e < IDX_W'(PACKETS_PER_BUFFER));
        data_off = pos_e - POS_W'(imufp_pkg::POS_DATA_LO);
        n_pos    = pos_e;
        n_idx    = idx_e;
        n_abort  = abort_e;
        n_type   = r_type;
        n_hold   = r_hold;
        n_words  = r_words;
        emit     = 1'b0;
        kind     = imufp_pkg::KIND_RATE;

        // Type precedence: rate, then angle, then quaternion
        if (r_type == r_gyro) begin
            kind = imufp_pkg::KIND_RATE;
        end else if (r_type == r_angle) begin
            kind = imufp_pkg::KIND_ANGLE;
        end else begin
            kind = imufp_pkg::KIND_QUAT;
        end

        if (active) begin
            if (pos_e == '0 && rx != r_head) begin
                n_abort = 1'b1;
            end else begin
                if (pos_e == POS_W'(imufp_pkg::POS_TYPE)) begin
                    n_type = rx;
                end else if (pos_e >= POS_W'(imufp_pkg::POS_DATA_LO) &&
                             pos_e <= POS_W'(imufp_pkg::POS_DATA_LAST)) begin
                    if (!data_off[0]) begin
                        n_hold = rx;
                    end else begin
                        n_words[data_off[2:1]] = {rx, r_hold};
                    end
                    if (pos_e == POS_W'(imufp_pkg::POS_DATA_LAST)) begin
                        emit = (r_type == r_gyro) || (r_type == r_angle) ||
                               (r_type == r_quat);
                    end
                end
                if (pos_e == POS_W'(PACKET_BYTES - 1)) begin
                    n_pos = '0;
                    n_idx = idx_e + IDX_W'(1);
                end else begin
                    n_pos = pos_e + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idx   <= '0;
            r_abort <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_abort <= n_abort;
        end
    end

    // Packet payload, always written before byte 9 reads it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= n_type;
            r_hold  <= n_hold;
            r_words <= n_words;
        end
    end

    // Yaw unwrap on angle results
    assign unwrap_req.en  = accept && emit && (kind == imufp_pkg::KIND_ANGLE);
    assign unwrap_req.yaw = r_words[2];
    assign unwrap_req.thr = r_thr;

    imufp_unwrap u_unwrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (unwrap_req),
        .o_yaw_cont (yaw_cont)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_kind <= kind;
            r_out_a    <= r_words[0];
            r_out_b    <= r_words[1];
            r_out_c    <= r_words[2];
            r_out_d    <= (kind == imufp_pkg::KIND_QUAT) ? {rx, r_hold} : 16'h0000;
            r_out_yaw  <= (kind == imufp_pkg::KIND_ANGLE) ? yaw_cont : 32'sd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {r_out_yaw, r_out_d, r_out_c, r_out_b, r_out_a};

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(PACKET_BYTES - 1))
        else $error("packet byte position out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(PACKETS_PER_BUFFER))
        else $error("packet index beyond buffer");

    a_word_d_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != imufp_pkg::KIND_QUAT) |-> o_m_tdata[63:48] == 16'h0000)
        else $error("word_d nonzero on a non-quaternion result");

    a_yaw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != imufp_pkg::KIND_ANGLE) |-> o_m_tdata[95:64] == 32'h0)
        else $error("continuous yaw nonzero on a non-angle result");

    a_emit_after_byte9: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid)) |-> $past(accept) && $past(r_pos) ==
            ($past(i_s_tuser[0]) ? POS_W'(0) : POS_W'(imufp_pkg::POS_DATA_LAST)))
        else $error("result raised without a byte 9 transfer");
`endif

endmodule

### test/imu_frame_parser_yaw_unwrap_tb.sv
`timescale 1ns / 1ps

module imu_frame_parser_yaw_unwrap_tb;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BYTES = 210;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 4;

    // first index past the register list; writes there must be ignored
    localparam logic [imufp_pkg::CFG_IDX_W-1:0] REG_SPARE =
        imufp_pkg::REG_WRAP_THRESHOLD + 3'd1;

    typedef struct {
        bit [1:0]  kind;
        bit [15:0] word_a;
        bit [15:0] word_b;
        bit [15:0] word_c;
        bit [15:0] word_d;
        bit [31:0] yaw_cont;
    } t_parsed_result;

    // Scoreboard: tracks the parser state and queues the expected results
    class imu_frame_scoreboard;
        bit [7:0]       cfg_head;
        bit [7:0]       cfg_gyro;
        bit [7:0]       cfg_angle;
        bit [7:0]       cfg_quat;
        bit [15:0]      cfg_wrap_thr;
        int             pos;
        int             pkt_idx;
        bit             aborted;
        bit [7:0]       pkt_type;
        bit [15:0]      frame_words [4];
        bit [7:0]       low_hold;
        bit [15:0]      prev_yaw;
        bit [15:0]      turns;
        t_parsed_result expected_frames [$];
        int             errors;

        function new();
            cfg_head     = imufp_pkg::HEAD_BYTE_RST;
            cfg_gyro     = imufp_pkg::GYRO_TYPE_RST;
            cfg_angle    = imufp_pkg::ANGLE_TYPE_RST;
            cfg_quat     = imufp_pkg::QUAT_TYPE_RST;
            cfg_wrap_thr = imufp_pkg::WRAP_THRESHOLD_RST;
            pos          = 0;
            pkt_idx      = 0;
            aborted      = 1'b0;
            pkt_type     = '0;
            foreach (frame_words[k]) frame_words[k] = '0;
            low_hold     = '0;
            prev_yaw     = '0;
            turns        = '0;
            errors       = 0;
        endfunction

        function void write_reg(bit [imufp_pkg::CFG_IDX_W-1:0] idx, bit [15:0] data);
            case (idx)
                imufp_pkg::REG_HEAD_BYTE:      cfg_head     = data[7:0];
                imufp_pkg::REG_GYRO_TYPE:      cfg_gyro     = data[7:0];
                imufp_pkg::REG_ANGLE_TYPE:     cfg_angle    = data[7:0];
                imufp_pkg::REG_QUAT_TYPE:      cfg_quat     = data[7:0];
                imufp_pkg::REG_WRAP_THRESHOLD: cfg_wrap_thr = data;
                default: ;
            endcase
        endfunction

        // unwrapped yaw: count wraps on large jumps, saturate count and sum
        function bit [31:0] predict_continuous_yaw(bit [15:0] raw);
            int     now;
            int     diff;
            int     cnt;
            int     thr;
            longint sum;
            now  = int'($signed(raw));
            diff = now - int'($signed(prev_yaw));
            cnt  = int'($signed(turns));
            thr  = int'(cfg_wrap_thr);
            if (diff > thr && cnt > -32768) cnt--;
            if (diff < -thr && cnt < 32767) cnt++;
            turns    = cnt[15:0];
            prev_yaw = raw;
            sum = longint'(now) + longint'(cnt) * 65536;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            return sum[31:0];
        endfunction

        // one accepted byte
        function void note_byte(bit [7:0] b, bit start);
            t_parsed_result r;
            bit             known;
            if (start) begin
                pos     = 0;
                pkt_idx = 0;
                aborted = 1'b0;
            end
            if (aborted || pkt_idx >= imufp_pkg::PACKETS_PER_BUFFER_DEF) return;
            if (pos == 0) begin
                if (b != cfg_head) begin
                    aborted = 1'b1;
                    return;
                end
            end else if (pos == imufp_pkg::POS_TYPE) begin
                pkt_type = b;
            end else if (pos <= imufp_pkg::POS_DATA_LAST) begin
                if (((pos - imufp_pkg::POS_DATA_LO) % 2) == 0) low_hold = b;
                else frame_words[(pos - imufp_pkg::POS_DATA_LO) / 2] = {b, low_hold};
                if (pos == imufp_pkg::POS_DATA_LAST) begin
                    known = 1'b1;
                    if (pkt_type == cfg_gyro) r.kind = imufp_pkg::KIND_RATE;
                    else if (pkt_type == cfg_angle) r.kind = imufp_pkg::KIND_ANGLE;
                    else if (pkt_type == cfg_quat) r.kind = imufp_pkg::KIND_QUAT;
                    else known = 1'b0;
                    if (known) begin
                        r.word_a   = frame_words[0];
                        r.word_b   = frame_words[1];
                        r.word_c   = frame_words[2];
                        r.word_d   = (r.kind == imufp_pkg::KIND_QUAT) ?
                                     frame_words[3] : '0;
                        r.yaw_cont = (r.kind == imufp_pkg::KIND_ANGLE) ?
                                     predict_continuous_yaw(frame_words[2]) : '0;
                        expected_frames.push_back(r);
                    end
                end
            end
            pos++;
            if (pos >= imufp_pkg::PACKET_BYTES_DEF) begin
                pos = 0;
                pkt_idx++;
            end
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // one accepted result
        function void check_result(bit [1:0] kind, bit [95:0] data);
            t_parsed_result e;
            if (expected_frames.size() == 0) begin
                $error("result with nothing pending: kind %0d", kind);
                errors++;
                return;
            end
            e = expected_frames.pop_front();
            cmp("packet_kind", e.kind, kind);
            cmp("word_a", $signed(e.word_a), $signed(data[15:0]));
            cmp("word_b", $signed(e.word_b), $signed(data[31:16]));
            cmp("word_c", $signed(e.word_c), $signed(data[47:32]));
            cmp("word_d", $signed(e.word_d), $signed(data[63:48]));
            cmp("yaw_continuous", $signed(e.yaw_cont), $signed(data[95:64]));
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata;
    logic [0:0]                      i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [95:0]                     o_m_tdata;
    logic [1:0]                      o_m_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [imufp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]                     i_cfg_data;

    imu_frame_scoreboard sb;
    bit                  src_idle_en;
    bit                  sink_idle_en;
    bit                  hold_req;
    int                  phase_bytes;
    bit [15:0]           yaw_gen;
    int                  idle_cycles;

    imu_frame_parser_yaw_unwrap uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: random stall bursts, plus one long hold on request
    initial begin : result_sink
        int stall;
        stall      = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (stall == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Byte transfer; entered and left at a falling edge, tvalid left high
    task automatic send_byte(input bit [7:0] b, input bit start);
        if (src_idle_en && $urandom_range(0, 9) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b, start);
        phase_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input bit [7:0] head, input bit [7:0] ty,
                               input bit [63:0] w, input int nbytes,
                               input bit first_start);
        bit [7:0] pkt_bytes [imufp_pkg::PACKET_BYTES_DEF];
        pkt_bytes[0]                   = head;
        pkt_bytes[imufp_pkg::POS_TYPE] = ty;
        for (int k = 0; k < 8; k++) pkt_bytes[imufp_pkg::POS_DATA_LO + k] = w[8*k +: 8];
        for (int k = imufp_pkg::POS_DATA_LAST + 1; k < imufp_pkg::PACKET_BYTES_DEF; k++)
            pkt_bytes[k] = 8'($urandom);
        for (int k = 0; k < nbytes; k++) send_byte(pkt_bytes[k], first_start && k == 0);
    endtask

    task automatic write_reg(input bit [imufp_pkg::CFG_IDX_W-1:0] idx,
                             input bit [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Register settings per phase; block is idle here
    task automatic apply_settings(input int ph);
        bit [7:0]  h;
        bit [7:0]  g;
        bit [7:0]  a;
        bit [7:0]  q;
        bit [15:0] t;
        h = 8'($urandom);
        g = 8'($urandom);
        a = g + 8'd1;
        q = g + 8'd2;
        t = 16'($urandom);
        case (ph)
            1: begin
                h = 8'h00; g = 8'hFF; a = 8'h00; q = 8'h80; t = 16'h0000;
            end
            2: begin
                h = 8'hFF; g = 8'h01; a = 8'h7F; q = 8'hFE; t = 16'hFFFF;
            end
            4: begin
                a = g; q = g;
            end
            5: begin
                q = a;
            end
            6: t = 16'($urandom_range(0, 2000));
            7: begin
                h = imufp_pkg::HEAD_BYTE_RST; g = imufp_pkg::GYRO_TYPE_RST;
                a = imufp_pkg::ANGLE_TYPE_RST; q = imufp_pkg::QUAT_TYPE_RST;
                t = imufp_pkg::WRAP_THRESHOLD_RST;
            end
            default: ;
        endcase
        // upper data bits are junk for the byte-wide registers
        write_reg(imufp_pkg::REG_HEAD_BYTE, {8'($urandom), h});
        write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
        write_reg(imufp_pkg::REG_GYRO_TYPE, {8'($urandom), g});
        write_reg(imufp_pkg::REG_ANGLE_TYPE, {8'($urandom), a});
        write_reg(imufp_pkg::REG_QUAT_TYPE, {8'($urandom), q});
        write_reg(imufp_pkg::REG_WRAP_THRESHOLD, t);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Yaw sequence with small steps, jumps across the wrap and extremes
    function automatic bit [15:0] next_yaw();
        case ($urandom_range(0, 5))
            0: yaw_gen = yaw_gen + 16'($urandom_range(0, 2000)) - 16'd1000;
            1: yaw_gen = $signed(yaw_gen) >= 0 ? 16'h8000 + 16'($urandom_range(0, 3000))
                                                : 16'h7FFF - 16'($urandom_range(0, 3000));
            2: yaw_gen = 16'($urandom);
            3: yaw_gen = 16'h7FFF;
            4: yaw_gen = 16'h8000;
            default: yaw_gen = 16'h0000;
        endcase
        return yaw_gen;
    endfunction

    function automatic bit [7:0] pick_type();
        bit [7:0] ty;
        case ($urandom_range(0, 9))
            0, 1, 2:    ty = sb.cfg_gyro;
            3, 4, 5, 6: ty = sb.cfg_angle;
            7, 8:       ty = sb.cfg_quat;
            default: begin
                ty = 8'($urandom);
                while (ty == sb.cfg_gyro || ty == sb.cfg_angle || ty == sb.cfg_quat)
                    ty = 8'($urandom);
            end
        endcase
        return ty;
    endfunction

    // One buffer: mostly well formed, some short, padded, broken or noise
    task automatic send_random_buffer();
        int        mode;
        int        cut;
        int        bad;
        int        sent;
        int        nb;
        bit [7:0]  head;
        bit [7:0]  ty;
        bit [63:0] w;
        mode = $urandom_range(0, 19);
        if (mode >= 18) begin
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom), $urandom_range(0, 5) == 0);
            return;
        end
        cut  = (mode == 12 || mode == 13) ? $urandom_range(1, 32)
               : imufp_pkg::PACKET_BYTES_DEF * imufp_pkg::PACKETS_PER_BUFFER_DEF;
        bad  = (mode == 16 || mode == 17)
               ? $urandom_range(0, imufp_pkg::PACKETS_PER_BUFFER_DEF - 1)
               : imufp_pkg::PACKETS_PER_BUFFER_DEF;
        sent = 0;
        for (int p = 0; p < imufp_pkg::PACKETS_PER_BUFFER_DEF && sent < cut; p++) begin
            nb   = (cut - sent < imufp_pkg::PACKET_BYTES_DEF) ? cut - sent
                                                               : imufp_pkg::PACKET_BYTES_DEF;
            head = sb.cfg_head;
            if (p == bad) begin
                head = 8'($urandom);
                while (head == sb.cfg_head) head = 8'($urandom);
            end
            ty = pick_type();
            w  = {32'($urandom), 32'($urandom)};
            case ($urandom_range(0, 7))
                0: w = {4{16'h8000}};
                1: w = {4{16'h7FFF}};
                default: ;
            endcase
            if (ty == sb.cfg_angle) w[47:32] = next_yaw();
            send_packet(head, ty, w, nb, p == 0);
            sent += nb;
        end
        if (mode == 14 || mode == 15)
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
    endtask

    // Wait until every expected result has arrived, then a short settle
    task automatic finish_phase();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    initial begin : main_flow
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        yaw_gen      = '0;
        idle_cycles  = 0;
        sb = new();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            if (ph > 0) apply_settings(ph);
            if (ph == 0) begin
                // angle packet with extreme words, full length
                send_packet(imufp_pkg::HEAD_BYTE_RST, imufp_pkg::ANGLE_TYPE_RST,
                            {16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000},
                            imufp_pkg::PACKET_BYTES_DEF, 1'b1);
                // rate packet cut right after its last data byte
                send_packet(imufp_pkg::HEAD_BYTE_RST, imufp_pkg::GYRO_TYPE_RST,
                            {16'h1234, 16'h7FFF, 16'hFFFF, 16'h0000},
                            imufp_pkg::POS_DATA_LAST + 1, 1'b0);
                // new buffer with a bad head, then a byte that must be ignored
                send_byte(8'h00, 1'b1);
                send_byte(imufp_pkg::HEAD_BYTE_RST, 1'b0);
                yaw_gen = 16'h8000;
            end
            // long receiver hold while bytes keep coming
            if (ph == 2) hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) send_random_buffer();
            finish_phase();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
